@@ hw/rtl/b64lw_pkg.sv @@
// Package for the base64 encoder with line wrapping.
// Holds the character constants, register indexes and the sextet lookup.
// Used by base64_encoder_line_wrap_unit; depends on nothing else.
`default_nettype none

package b64lw_pkg;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_PAD = 8'd61;

  localparam logic [6:0] LINE_LEN_RESET = 7'd72;
  localparam logic [6:0] LINE_LEN_MIN   = 7'd16;
  localparam logic [6:0] LINE_LEN_MAX   = 7'd76;

  localparam int unsigned BURST_DEPTH = 6;

  typedef enum logic [1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_USE_CRLF    = 2'd1
  } reg_index_t;

  typedef logic [BURST_DEPTH-1:0][7:0] burst_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/base64_encoder_line_wrap_unit.sv @@
// Streaming base64 encoder with line wrapping, one character per output beat.
// The characters of a taken beat go into the character buffer register, then one by one into the
// single character output register, which holds while out_stall is high. The input stalls while
// an item's characters drain, also for beats that emit nothing and only hold their byte.
// Reset (synchronous, active low) clears pending bytes, the column and the character buffer.
// Depends on b64lw_pkg.
`default_nettype none

module base64_encoder_line_wrap_unit
  import b64lw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_last_char
);

  logic [6:0] line_length_r;
  logic       use_crlf_r;
  logic [7:0] held0_r;
  logic [7:0] held1_r;
  logic [1:0] held_count_r;
  logic [6:0] col_r;

  burst_t     burst_r;
  logic       burst_valid_r;
  logic [2:0] burst_idx_r;
  logic [2:0] burst_cnt_r;
  logic       burst_fin_r;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic [6:0] eff_len;
  logic       in_acc;
  logic       out_ld;
  logic       drain_done;
  logic       full_grp;
  logic       emit;
  logic [7:0] ga, gb, gc;
  logic [6:0] col4;
  logic       brk;
  logic       col_brk;
  burst_t     burst_nxt;
  logic [2:0] cnt_nxt;
  logic [6:0] col_nxt;
  logic [1:0] held_count_nxt;

  assign eff_len = (line_length_r >= LINE_LEN_MIN && line_length_r <= LINE_LEN_MAX) ?
                   {line_length_r[6:2], 2'b00} : LINE_LEN_RESET;

  assign out_ld     = !out_valid_r || !out_stall;
  assign drain_done = burst_valid_r && out_ld && (burst_idx_r == burst_cnt_r - 3'd1);
  assign in_stall   = burst_valid_r && !drain_done;
  assign in_acc     = in_valid && !in_stall;

  always_comb begin
    full_grp = held_count_r[1];
    emit     = full_grp || in_final_byte;
    if (full_grp) begin
      ga = held0_r;
      gb = held1_r;
      gc = in_data_byte;
    end else if (held_count_r[0]) begin
      ga = held0_r;
      gb = in_data_byte;
      gc = 8'd0;
    end else begin
      ga = in_data_byte;
      gb = 8'd0;
      gc = 8'd0;
    end
    col4    = col_r + 7'd4;
    col_brk = full_grp && (col4 >= eff_len);
    brk     = col_brk || (in_final_byte && col4 != 7'd0);

    burst_nxt[0] = sextet_char(ga[7:2]);
    burst_nxt[1] = sextet_char({ga[1:0], gb[7:4]});
    burst_nxt[2] = (full_grp || held_count_r[0]) ? sextet_char({gb[3:0], gc[7:6]}) : CH_PAD;
    burst_nxt[3] = full_grp ? sextet_char(gc[5:0]) : CH_PAD;
    burst_nxt[4] = use_crlf_r ? CH_CR : CH_LF;
    burst_nxt[5] = CH_LF;

    if (!brk) begin
      cnt_nxt = 3'd4;
    end else if (use_crlf_r) begin
      cnt_nxt = 3'd6;
    end else begin
      cnt_nxt = 3'd5;
    end

    if (in_final_byte || col_brk) begin
      col_nxt = 7'd0;
    end else if (full_grp) begin
      col_nxt = col4;
    end else begin
      col_nxt = col_r;
    end

    held_count_nxt = emit ? 2'd0 : held_count_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LEN_RESET;
      use_crlf_r    <= 1'b0;
      held_count_r  <= 2'd0;
      col_r         <= 7'd0;
      held0_r       <= 8'd0;
      held1_r       <= 8'd0;
      burst_valid_r <= 1'b0;
      burst_idx_r   <= 3'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LINE_LENGTH) begin
          line_length_r <= cfg_data;
        end else if (cfg_index == REG_USE_CRLF) begin
          use_crlf_r <= cfg_data[0];
        end
      end

      if (out_ld) begin
        out_valid_r <= burst_valid_r;
        if (burst_valid_r) begin
          out_char_r <= burst_r[burst_idx_r];
          out_last_r <= burst_fin_r && (burst_idx_r == burst_cnt_r - 3'd1);
        end
      end

      if (in_acc) begin
        held_count_r <= held_count_nxt;
        col_r        <= col_nxt;
        if (!emit && !held_count_r[0]) begin
          held0_r <= in_data_byte;
        end
        if (!emit && held_count_r[0]) begin
          held1_r <= in_data_byte;
        end
      end

      if (in_acc && emit) begin
        burst_r       <= burst_nxt;
        burst_cnt_r   <= cnt_nxt;
        burst_fin_r   <= in_final_byte;
        burst_idx_r   <= 3'd0;
        burst_valid_r <= 1'b1;
      end else begin
        if (drain_done) begin
          burst_valid_r <= 1'b0;
        end
        if (out_ld && burst_valid_r) begin
          burst_idx_r <= burst_idx_r + 3'd1;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  a_held_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r != 2'd3)
    else $error("held byte count out of range");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_byte |=> col_r == 7'd0 && held_count_r == 2'd0)
    else $error("final beat did not clear column and held bytes");

  a_stall_needs_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> burst_valid_r)
    else $error("input stalled without pending characters");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    burst_valid_r |-> burst_idx_r < burst_cnt_r && burst_cnt_r >= 3'd4)
    else $error("burst index beyond character count");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_char_r == CH_LF)
    else $error("last character of a message is not a line feed");

endmodule

`default_nettype wire
